[sv/iirdf1_pkg.sv]
// ============================================================================
// iirdf1_pkg
// Shared types, constants and the microprogram of the direct form I IIR filter.
// ============================================================================
package iirdf1_pkg;

  // Fixed widths of the coefficient path and the accumulator.
  localparam int COEFF_WIDTH   = 16;
  localparam int ACC_WIDTH     = 40;
  localparam int HIST_DEPTH    = 3;
  localparam int NUM_COEFFS    = 7;

  // Configuration port geometry: seven 32-bit registers at word addresses.
  localparam int CFG_ADDR_W    = 5;
  localparam int CFG_DATA_W    = 32;
  localparam int REG_IDX_W     = 3;
  localparam int REG_IDX_LO    = 2;

  // Reset value of the current-sample weight, 1.0 in Q2.14.
  localparam logic [COEFF_WIDTH-1:0] COEFF_B0_RESET = 16'd16384;

  // Register indexes of the configuration space.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEFF_B0 = 3'd0,
    REG_COEFF_B1 = 3'd1,
    REG_COEFF_B2 = 3'd2,
    REG_COEFF_B3 = 3'd3,
    REG_COEFF_A1 = 3'd4,
    REG_COEFF_A2 = 3'd5,
    REG_COEFF_A3 = 3'd6
  } reg_idx_t;

  // All seven coefficients, indexed by register index.
  typedef logic [NUM_COEFFS-1:0][COEFF_WIDTH-1:0] coeff_set_t;

  // Coefficient set after reset: b0 = 1.0, every other weight zero.
  localparam coeff_set_t COEFF_SET_RESET =
    {{((NUM_COEFFS-1)*COEFF_WIDTH){1'b0}}, COEFF_B0_RESET};

  // Product term selected for the shared multiplier.
  typedef enum logic [2:0] {
    TAP_B0 = 3'd0,
    TAP_B1 = 3'd1,
    TAP_B2 = 3'd2,
    TAP_B3 = 3'd3,
    TAP_A1 = 3'd4,
    TAP_A2 = 3'd5,
    TAP_A3 = 3'd6
  } tap_t;

  // Accumulator operation of one step.
  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_CLR  = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_op_t;

  // Condition on which a step repeats itself.
  typedef enum logic [1:0] {
    WAIT_NONE   = 2'd0,
    WAIT_INPUT  = 2'd1,
    WAIT_OUTPUT = 2'd2
  } wait_t;

  // Microprogram geometry and step labels.
  localparam int STEP_W      = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_FINISH = 4'd9;

  // One control word of the microprogram.
  typedef struct packed {
    wait_t              wait_on;
    logic               jump;
    logic [STEP_W-1:0]  target;
    logic               accept;
    logic               mul_en;
    tap_t               tap;
    acc_op_t            acc_op;
    logic               finish;
  } ucode_t;

  // Control from the sequencer to the datapath, already qualified.
  typedef struct packed {
    logic    load_in;
    logic    mul_en;
    tap_t    tap;
    acc_op_t acc_op;
    logic    finish;
  } dp_ctrl_t;

  // Microprogram ROM. The multiplier product registered in one step is
  // accumulated in the next, so step k+1 adds the product of step k.
  function automatic ucode_t ucode_word(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{wait_on: WAIT_NONE, jump: 1'b0, target: STEP_IDLE, accept: 1'b0,
          mul_en: 1'b0, tap: TAP_B0, acc_op: ACC_HOLD, finish: 1'b0};
    unique case (step)
      STEP_IDLE: begin
        w.wait_on = WAIT_INPUT;
        w.accept  = 1'b1;
        w.acc_op  = ACC_CLR;
      end
      4'd1: begin
        w.mul_en = 1'b1;
        w.tap    = TAP_B0;
      end
      4'd2: begin
        w.mul_en = 1'b1;
        w.tap    = TAP_B1;
        w.acc_op = ACC_ADD;
      end
      4'd3: begin
        w.mul_en = 1'b1;
        w.tap    = TAP_B2;
        w.acc_op = ACC_ADD;
      end
      4'd4: begin
        w.mul_en = 1'b1;
        w.tap    = TAP_B3;
        w.acc_op = ACC_ADD;
      end
      4'd5: begin
        w.mul_en = 1'b1;
        w.tap    = TAP_A1;
        w.acc_op = ACC_ADD;
      end
      4'd6: begin
        w.mul_en = 1'b1;
        w.tap    = TAP_A2;
        w.acc_op = ACC_SUB;
      end
      4'd7: begin
        w.mul_en = 1'b1;
        w.tap    = TAP_A3;
        w.acc_op = ACC_SUB;
      end
      4'd8: begin
        w.acc_op = ACC_SUB;
      end
      STEP_FINISH: begin
        w.wait_on = WAIT_OUTPUT;
        w.finish  = 1'b1;
        w.jump    = 1'b1;
        w.target  = STEP_IDLE;
      end
      default: begin
        // Unused step codes return to the idle step.
        w.jump   = 1'b1;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[sv/iirdf1_sequencer.sv]
// ============================================================================
// iirdf1_sequencer
// Step counter and microprogram ROM that drive the filter datapath.
// ============================================================================
module iirdf1_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_busy,
  output logic                in_ready,
  output iirdf1_pkg::dp_ctrl_t dp_ctrl
);
  import iirdf1_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  ucode_t            word;
  logic              stall;

  // Fetch the control word of the current step.
  assign word = ucode_word(step_r);

  // A step repeats while the condition it waits on is not met.
  always_comb begin
    unique case (word.wait_on)
      WAIT_INPUT:  stall = !in_valid;
      WAIT_OUTPUT: stall = out_busy;
      default:     stall = 1'b0;
    endcase
  end

  // Next step: hold, jump or fall through.
  always_comb begin
    priority if (stall) begin
      step_nxt = step_r;
    end else if (word.jump) begin
      step_nxt = word.target;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // The input transfer happens in the accepting step.
  assign in_ready = word.accept;

  // Qualified controls for the datapath.
  always_comb begin
    dp_ctrl.load_in = word.accept && in_valid;
    dp_ctrl.mul_en  = word.mul_en;
    dp_ctrl.tap     = word.tap;
    dp_ctrl.acc_op  = word.acc_op;
    dp_ctrl.finish  = word.finish && !stall;
  end

endmodule

[sv/iirdf1_datapath.sv]
// ============================================================================
// iirdf1_datapath
// Delay lines, shared multiplier, accumulator, rounding and output register.
// ============================================================================
module iirdf1_datapath #(
  parameter int FEEDFORWARD_TAPS = 4,
  parameter int FEEDBACK_TAPS    = 3,
  parameter int SAMPLE_WIDTH     = 16,
  parameter int COEFF_FRAC_BITS  = 14
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  iirdf1_pkg::dp_ctrl_t             dp_ctrl,
  input  iirdf1_pkg::coeff_set_t           coeffs,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_sample_in,
  input  logic                             in_clear_history,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic signed [SAMPLE_WIDTH-1:0]   out_sample_out,
  output logic                             out_saturated
);
  import iirdf1_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + COEFF_WIDTH;
  localparam int RW     = ACC_WIDTH + 1;
  localparam logic signed [RW-1:0] ROUND_K = RW'(1) << (COEFF_FRAC_BITS - 1);
  localparam logic signed [RW-1:0] SMAX    = (RW'(1) << (SAMPLE_WIDTH - 1)) - RW'(1);
  localparam logic signed [RW-1:0] SMIN    = -SMAX - RW'(1);

  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic signed [SAMPLE_WIDTH-1:0] xh_r [HIST_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] yh_r [HIST_DEPTH];
  logic signed [PROD_W-1:0]       prod_r;
  logic signed [ACC_WIDTH-1:0]    acc_r;
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                           out_sat_r;

  logic signed [COEFF_WIDTH-1:0]  coef_sel;
  logic signed [SAMPLE_WIDTH-1:0] op_sel;
  logic signed [PROD_W-1:0]       prod_nxt;
  logic signed [ACC_WIDTH-1:0]    prod_ext;
  logic signed [ACC_WIDTH-1:0]    acc_nxt;
  logic signed [RW-1:0]           rounded;
  logic signed [RW-1:0]           shifted;
  logic                           sat_hi;
  logic                           sat_lo;
  logic signed [SAMPLE_WIDTH-1:0] y_nxt;

  // Operand selection for the shared multiplier; taps beyond the
  // configured counts weigh zero.
  always_comb begin
    unique case (dp_ctrl.tap)
      TAP_B0: begin
        coef_sel = coeffs[REG_COEFF_B0];
        op_sel   = x_r;
      end
      TAP_B1: begin
        coef_sel = (FEEDFORWARD_TAPS > 1) ? coeffs[REG_COEFF_B1] : '0;
        op_sel   = xh_r[0];
      end
      TAP_B2: begin
        coef_sel = (FEEDFORWARD_TAPS > 2) ? coeffs[REG_COEFF_B2] : '0;
        op_sel   = xh_r[1];
      end
      TAP_B3: begin
        coef_sel = (FEEDFORWARD_TAPS > 3) ? coeffs[REG_COEFF_B3] : '0;
        op_sel   = xh_r[2];
      end
      TAP_A1: begin
        coef_sel = (FEEDBACK_TAPS >= 1) ? coeffs[REG_COEFF_A1] : '0;
        op_sel   = yh_r[0];
      end
      TAP_A2: begin
        coef_sel = (FEEDBACK_TAPS >= 2) ? coeffs[REG_COEFF_A2] : '0;
        op_sel   = yh_r[1];
      end
      TAP_A3: begin
        coef_sel = (FEEDBACK_TAPS >= 3) ? coeffs[REG_COEFF_A3] : '0;
        op_sel   = yh_r[2];
      end
      default: begin
        coef_sel = '0;
        op_sel   = '0;
      end
    endcase
  end

  assign prod_nxt = coef_sel * op_sel;
  assign prod_ext = ACC_WIDTH'(prod_r);

  // Accumulator update; the sum wraps at the accumulator width.
  always_comb begin
    unique case (dp_ctrl.acc_op)
      ACC_CLR: acc_nxt = '0;
      ACC_ADD: acc_nxt = acc_r + prod_ext;
      ACC_SUB: acc_nxt = acc_r - prod_ext;
      default: acc_nxt = acc_r;
    endcase
  end

  // Round half up, drop the fraction bits and clip to the sample range.
  always_comb begin
    rounded = RW'(acc_r) + ROUND_K;
    shifted = rounded >>> COEFF_FRAC_BITS;
    sat_hi  = shifted > SMAX;
    sat_lo  = shifted < SMIN;
    priority if (sat_hi) begin
      y_nxt = SMAX[SAMPLE_WIDTH-1:0];
    end else if (sat_lo) begin
      y_nxt = SMIN[SAMPLE_WIDTH-1:0];
    end else begin
      y_nxt = shifted[SAMPLE_WIDTH-1:0];
    end
  end

  // Delay lines and output handshake state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        xh_r[i] <= '0;
        yh_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (dp_ctrl.load_in && in_clear_history) begin
        for (int i = 0; i < HIST_DEPTH; i++) begin
          xh_r[i] <= '0;
          yh_r[i] <= '0;
        end
      end
      if (dp_ctrl.finish) begin
        for (int i = HIST_DEPTH - 1; i > 0; i--) begin
          xh_r[i] <= xh_r[i-1];
          yh_r[i] <= yh_r[i-1];
        end
        xh_r[0] <= x_r;
        yh_r[0] <= y_nxt;
      end
      if (dp_ctrl.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (dp_ctrl.load_in) begin
      x_r <= in_sample_in;
    end
    if (dp_ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
    acc_r <= acc_nxt;
    if (dp_ctrl.finish) begin
      out_sample_r <= y_nxt;
      out_sat_r    <= sat_hi || sat_lo;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_saturated  = out_sat_r;

endmodule

[sv/iir_direct_form_one_filter_unit.sv]
// ============================================================================
// iir_direct_form_one_filter_unit
// Direct form I IIR filter, four feedforward and three feedback taps, with
// Q2.14 coefficients, a 40-bit accumulator and a saturated output.
//
//   Channel  Ports                         Moves
//   input    in_valid / in_ready           one sample and its clear flag
//   output   out_valid / out_ready         one filtered sample and clip flag
//   config   cfg_psel / cfg_penable ...    coefficient writes and reads
//
// A sample is taken in step 0 and its result is loaded into the output
// register in the final step; a new sample is taken only after that. The
// single shared multiplier forms the seven products one per step. Reset
// clears both delay lines and the output valid flag and sets the coefficients
// to b0 = 1.0, all others zero. While a result still waits in the output
// register the next sample is taken and computed; the final step holds
// until the output register is free.
// ============================================================================
module iir_direct_form_one_filter_unit #(
  parameter int FEEDFORWARD_TAPS = 4,
  parameter int FEEDBACK_TAPS    = 3,
  parameter int SAMPLE_WIDTH     = 16,
  parameter int COEFF_FRAC_BITS  = 14
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input channel.
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]        in_sample_in,
  input  logic                                  in_clear_history,
  // Result channel.
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]        out_sample_out,
  output logic                                  out_saturated,
  // Configuration port.
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [iirdf1_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [iirdf1_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [iirdf1_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                  cfg_pready
);
  import iirdf1_pkg::*;

  coeff_set_t           coeff_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_hit;
  logic                 cfg_wr;
  logic                 out_busy;
  dp_ctrl_t             dp_ctrl;

  // Register decode; addresses beyond the last coefficient are ignored.
  assign reg_idx = cfg_paddr[REG_IDX_LO +: REG_IDX_W];
  assign reg_hit = reg_idx <= REG_COEFF_A3;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite;

  // Coefficient registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= COEFF_SET_RESET;
    end else if (cfg_wr && reg_hit) begin
      coeff_r[reg_idx] <= cfg_pwdata[COEFF_WIDTH-1:0];
    end
  end

  // Read data is the sign-extended coefficient.
  always_comb begin
    if (reg_hit) begin
      cfg_prdata = CFG_DATA_W'(signed'(coeff_r[reg_idx]));
    end else begin
      cfg_prdata = '0;
    end
  end

  assign cfg_pready = 1'b1;

  // The final step waits while a result has not yet been transferred.
  assign out_busy = out_valid && !out_ready;

  iirdf1_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .in_ready (in_ready),
    .dp_ctrl  (dp_ctrl)
  );

  iirdf1_datapath #(
    .FEEDFORWARD_TAPS (FEEDFORWARD_TAPS),
    .FEEDBACK_TAPS    (FEEDBACK_TAPS),
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .COEFF_FRAC_BITS  (COEFF_FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .dp_ctrl          (dp_ctrl),
    .coeffs           (coeff_r),
    .in_sample_in     (in_sample_in),
    .in_clear_history (in_clear_history),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_sample_out   (out_sample_out),
    .out_saturated    (out_saturated)
  );

endmodule

[sv/iirdf1_checker.sv]
// ============================================================================
// iirdf1_checker
// Port-level checks of the IIR filter unit, bound to the top level.
// ============================================================================
module iirdf1_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  input logic                           out_saturated,
  input logic                           cfg_pready
);

  localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // No result is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A result not yet taken stays offered with the same value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out)
                                && $stable(out_saturated))
    else $error("pending result changed before its transfer");

  // After an input transfer the unit is busy computing for a while.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input taken again while an item was in progress");

  // A clipped result sits at one end of the sample range.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_sample_out == SMAX || out_sample_out == SMIN)
    else $error("clip flag set on a value inside the range");

  // The register port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("configuration port stalled");

endmodule

bind iir_direct_form_one_filter_unit iirdf1_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_iirdf1_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_sample_out (out_sample_out),
  .out_saturated  (out_saturated),
  .cfg_pready     (cfg_pready)
);
